// ----- rtl/lmcs_pkg.sv -----
// Types and bit maps for the LED matrix column scanner.
`timescale 1ns / 1ps

package lmcs_pkg;

  localparam int MaxColumns = 20;
  localparam int MaxRows    = 12;

  typedef enum logic [1:0] {
    REQ_SET     = 2'd0,
    REQ_CLEAR   = 2'd1,
    REQ_REFRESH = 2'd2,
    REQ_BLANK   = 2'd3
  } req_e;

  typedef struct packed {
    req_e       req_type;
    logic [4:0] pixel_x;
    logic [3:0] pixel_y;
    logic       pixel_on;
  } req_t;

  typedef struct packed {
    logic [31:0] shift_word;
    logic [4:0]  column_index;
    logic        last_word;
  } res_t;

  // What the output stage needs to format one word.
  typedef struct packed {
    logic [MaxRows-1:0] rows;
    logic [4:0]         col;
    logic               driven;
    logic               last;
  } word_src_t;

  typedef logic [4:0] pos_t;

  localparam pos_t COL_POS [MaxColumns] = '{
    5'd11, 5'd10, 5'd9,  5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd18, 5'd17,
    5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd8,  5'd16
  };

  localparam pos_t ROW_POS [MaxRows] = '{
    5'd12, 5'd13, 5'd14, 5'd15, 5'd0, 5'd4, 5'd3, 5'd2, 5'd1, 5'd5, 5'd6, 5'd7
  };

endpackage

// ----- rtl/lmcs_if.sv -----
// Request and result channel interfaces of the column scanner.
`timescale 1ns / 1ps

interface lmcs_req_if;
  import lmcs_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lmcs_res_if;
  import lmcs_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/lmcs_mask_store.sv -----
// Column mask memory with per-column valid bits for a clear of all columns at once.
`timescale 1ns / 1ps

module lmcs_mask_store #(
  parameter int NUM_COLUMNS = 20,
  parameter int NUM_ROWS    = 12,
  parameter int AW          = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_i,
  input  logic                ren_i,
  input  logic [AW-1:0]       raddr_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [NUM_ROWS-1:0] wdata_i,
  output logic [NUM_ROWS-1:0] rdata_o
);

  logic [NUM_ROWS-1:0]    mem [NUM_COLUMNS];
  logic [NUM_ROWS-1:0]    rdata_q;
  logic [NUM_COLUMNS-1:0] valid_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ren_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ren_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // A column never written since the last clear reads dark.
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- rtl/lmcs_out_stage.sv -----
// Shift word formatting and output register.
`timescale 1ns / 1ps

module lmcs_out_stage #(
  parameter int NUM_COLUMNS = 20,
  parameter int NUM_ROWS    = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lmcs_pkg::word_src_t src_i,
  output logic                free_o,
  lmcs_res_if.source          res_o
);

  import lmcs_pkg::*;

  logic        valid_q;
  res_t        res_q;
  logic [31:0] word;

  always_comb begin
    word = '0;
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      word[COL_POS[c]] = 1'b1;
    end
    if (src_i.driven && (src_i.col < 5'(NUM_COLUMNS))) begin
      word[COL_POS[src_i.col]] = 1'b0;
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (src_i.rows[r]) begin
        word[ROW_POS[r]] = 1'b1;
      end
    end
  end

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q.shift_word   <= word;
      res_q.column_index <= src_i.col;
      res_q.last_word    <= src_i.last;
    end
  end

  assign res_o.valid   = valid_q;
  assign res_o.payload = res_q;

endmodule

// ----- rtl/led_matrix_column_scanner.sv -----
// Top level of the LED matrix column scanner.
`timescale 1ns / 1ps

// Keeps a NUM_COLUMNS by NUM_ROWS on/off pixel store in a small synchronous
// memory, one row mask per column, dark after reset. A set-pixel word reads
// the column, then modifies and writes it back; the next request is taken in
// the cycle after the write, so no forwarding is needed. A clear word darkens
// the store at once through per-column valid bits. A refresh word reads one
// column per cycle while the output register is free and emits NUM_COLUMNS
// result words, one per cycle while the result side keeps up; a blank word
// loads its one result word into the output register once that is free.
// The memory read port sets the pace of a scan. One result word waits in the
// output register while the next request is taken.
module led_matrix_column_scanner #(
  parameter int NUM_COLUMNS = 20,
  parameter int NUM_ROWS    = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmcs_req_if.sink   req_i,
  lmcs_res_if.source res_o
);

  import lmcs_pkg::*;

  localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SET   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_BLANK = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] col_q, col_d;
  logic [AW-1:0] x_q, x_d;
  logic [RW-1:0] y_q, y_d;
  logic          on_q, on_d;

  logic                req_acc;
  logic                clr, ren, we;
  logic [AW-1:0]       raddr;
  logic [NUM_ROWS-1:0] rdata, wdata, ybit;
  logic                load, free;
  word_src_t           src;
  logic                last_col;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign last_col    = (col_q == AW'(NUM_COLUMNS - 1));
  assign ybit        = NUM_ROWS'(1) << y_q;
  assign wdata       = on_q ? (rdata | ybit) : (rdata & ~ybit);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    x_d     = x_q;
    y_d     = y_q;
    on_d    = on_q;
    clr     = 1'b0;
    ren     = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    load    = 1'b0;
    src     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          unique case (req_i.payload.req_type)
            REQ_SET: begin
              // Drop pixels outside the matrix.
              if ((req_i.payload.pixel_x < 5'(NUM_COLUMNS)) &&
                  (req_i.payload.pixel_y < 4'(NUM_ROWS))) begin
                x_d     = req_i.payload.pixel_x[AW-1:0];
                y_d     = req_i.payload.pixel_y[RW-1:0];
                on_d    = req_i.payload.pixel_on;
                ren     = 1'b1;
                raddr   = req_i.payload.pixel_x[AW-1:0];
                state_d = S_SET;
              end
            end
            REQ_CLEAR: begin
              clr = 1'b1;
            end
            REQ_REFRESH: begin
              col_d   = '0;
              ren     = 1'b1;
              raddr   = '0;
              state_d = S_SCAN;
            end
            REQ_BLANK: begin
              state_d = S_BLANK;
            end
            default: ;
          endcase
        end
      end
      S_SET: begin
        we      = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        // Hold the read data until the output register can take the word.
        if (free) begin
          load        = 1'b1;
          src.rows    = MaxRows'(rdata);
          src.col     = 5'(col_q);
          src.driven  = 1'b1;
          src.last    = last_col;
          if (last_col) begin
            state_d = S_IDLE;
          end else begin
            col_d = col_q + 1'b1;
            ren   = 1'b1;
            raddr = col_q + 1'b1;
          end
        end
      end
      S_BLANK: begin
        if (free) begin
          load       = 1'b1;
          src.col    = 5'(NUM_COLUMNS);
          src.last   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    on_q <= on_d;
  end

  lmcs_mask_store #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS),
    .AW          (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .ren_i   (ren),
    .raddr_i (raddr),
    .we_i    (we),
    .waddr_i (x_q),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  lmcs_out_stage #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .src_i  (src),
    .free_o (free),
    .res_o  (res_o)
  );

endmodule
